### design/cwas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwas_pkg
// Types, codes and helpers shared by the companion wake and arm sequencer.
// ----------------------------------------------------------------------------
package cwas_pkg;

    // Event commands
    localparam logic [3:0] CMD_TICK        = 4'd0;
    localparam logic [3:0] CMD_ARM         = 4'd1;
    localparam logic [3:0] CMD_BOOT        = 4'd2;
    localparam logic [3:0] CMD_READY       = 4'd3;
    localparam logic [3:0] CMD_SLEEP_SEEN  = 4'd4;
    localparam logic [3:0] CMD_STATUS      = 4'd5;
    localparam logic [3:0] CMD_CAP_DONE    = 4'd6;
    localparam logic [3:0] CMD_CAP_ISSUED  = 4'd7;
    localparam logic [3:0] CMD_VISIT_START = 4'd8;
    localparam logic [3:0] CMD_VISIT_END   = 4'd9;

    // Arm states
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_WAKING     = 3'd1;
    localparam logic [2:0] ST_WAITBOOT   = 3'd2;
    localparam logic [2:0] ST_WAITREADY  = 3'd3;
    localparam logic [2:0] ST_SETTLING   = 3'd4;
    localparam logic [2:0] ST_READY      = 3'd5;
    localparam logic [2:0] ST_CAPTURING  = 3'd6;
    localparam logic [2:0] ST_DISARMING  = 3'd7;

    // Actions
    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_WAKE       = 2'd1;
    localparam logic [1:0] ACT_DEEP_SLEEP = 2'd2;
    localparam logic [1:0] ACT_STATUS_REQ = 2'd3;

    // Notices
    localparam logic [4:0] NT_NONE          = 5'd0;
    localparam logic [4:0] NT_WAKE_PULSE    = 5'd1;
    localparam logic [4:0] NT_WAKE_FAILED   = 5'd2;
    localparam logic [4:0] NT_WAKE_RETRY    = 5'd3;
    localparam logic [4:0] NT_BOOT_SEEN     = 5'd4;
    localparam logic [4:0] NT_BOOT_CONFIRM  = 5'd5;
    localparam logic [4:0] NT_READY_SEEN    = 5'd6;
    localparam logic [4:0] NT_READY_DETECT  = 5'd7;
    localparam logic [4:0] NT_SLEEP_SEEN    = 5'd8;
    localparam logic [4:0] NT_DISARM_SLEEP  = 5'd9;
    localparam logic [4:0] NT_IDLE_SLEEP    = 5'd10;
    localparam logic [4:0] NT_VISIT_CAPTURE = 5'd11;
    localparam logic [4:0] NT_CAPTURE_READY = 5'd12;
    localparam logic [4:0] NT_CAP_DONE_OK   = 5'd13;
    localparam logic [4:0] NT_CAP_DONE_FAIL = 5'd14;
    localparam logic [4:0] NT_VISIT_START   = 5'd15;
    localparam logic [4:0] NT_VISIT_END     = 5'd16;

    // Visit reasons
    localparam logic [1:0] VR_NONE       = 2'd0;
    localparam logic [1:0] VR_ARMED      = 2'd1;
    localparam logic [1:0] VR_LATE       = 2'd2;
    localparam logic [1:0] VR_NO_CAPTURE = 2'd3;

    // Status kinds
    localparam logic [1:0] SK_ACTIVE     = 2'd1;
    localparam logic [1:0] SK_SLEEP_DEEP = 2'd2;

    // Flag bit positions
    localparam int FL_ACTIVE   = 0;
    localparam int FL_SETTLED  = 1;
    localparam int FL_SLEEPING = 2;
    localparam int FL_BOOT     = 3;
    localparam int FL_READY    = 4;
    localparam int FL_CAPPEND  = 5;
    localparam int FL_VISIT    = 6;
    localparam int FL_MEDIA    = 7;
    localparam int FL_METAONLY = 8;
    localparam int FL_QUEUED   = 9;

    // Configuration register indexes
    localparam logic [3:0] CFG_WAKE_INTERVAL  = 4'd0;
    localparam logic [3:0] CFG_BOOT_TIMEOUT   = 4'd1;
    localparam logic [3:0] CFG_READY_TIMEOUT  = 4'd2;
    localparam logic [3:0] CFG_SETTLE_TIMEOUT = 4'd3;
    localparam logic [3:0] CFG_SETTLE_DELAY   = 4'd4;
    localparam logic [3:0] CFG_IDLE_SLEEP     = 4'd5;
    localparam logic [3:0] CFG_EVENT_TIMEOUT  = 4'd6;
    localparam logic [3:0] CFG_MAX_RETRIES    = 4'd7;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 4;

    typedef struct packed {
        logic [3:0] command;
        logic       link_ok;
        logic [1:0] status_kind;
        logic       module_settled;
        logic       capture_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0] arm_state;
        logic [1:0] action;
        logic [4:0] notice;
        logic [1:0] visit_reason;
    } t_out_item;

    typedef struct packed {
        logic [19:0] wake_interval_ms;
        logic [19:0] boot_timeout_ms;
        logic [19:0] ready_timeout_ms;
        logic [19:0] settle_timeout_ms;
        logic [19:0] settle_delay_ms;
        logic [19:0] idle_sleep_ms;
        logic [19:0] event_timeout_ms;
        logic [3:0]  max_wake_retries;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  arm_state;
        logic [31:0] clock_ms;
        logic [31:0] wake_pulse_time;
        logic [31:0] boot_time;
        logic [31:0] ready_time;
        logic [31:0] settle_due_time;
        logic [31:0] capture_start_time;
        logic [31:0] last_activity_time;
        logic [3:0]  wake_retry_count;
        logic [9:0]  flags;
        logic [1:0]  capture_reason;
    } t_state;

    // Wrap-safe elapsed time
    function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] t);
        return now - t;
    endfunction

    // Widen a 20-bit millisecond setting to the clock width
    function automatic logic [31:0] ms32(input logic [19:0] v);
        return {12'd0, v};
    endfunction

endpackage

### design/cwas_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwas_cfg
// Configuration register bank: timeouts, delays and the wake retry limit.
// ----------------------------------------------------------------------------
module cwas_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [cwas_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [cwas_pkg::CFG_DATA_W-1:0]   i_data,
    output cwas_pkg::t_cfg                    o_cfg
);

    cwas_pkg::t_cfg r_cfg;

    // Load defaults on reset, take writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wake_interval_ms  <= 20'd2000;
            r_cfg.boot_timeout_ms   <= 20'd8000;
            r_cfg.ready_timeout_ms  <= 20'd8000;
            r_cfg.settle_timeout_ms <= 20'd1500;
            r_cfg.settle_delay_ms   <= 20'd500;
            r_cfg.idle_sleep_ms     <= 20'd90000;
            r_cfg.event_timeout_ms  <= 20'd15000;
            r_cfg.max_wake_retries  <= 4'd3;
        end else if (i_wr) begin
            case (i_idx)
                cwas_pkg::CFG_WAKE_INTERVAL:  r_cfg.wake_interval_ms  <= i_data;
                cwas_pkg::CFG_BOOT_TIMEOUT:   r_cfg.boot_timeout_ms   <= i_data;
                cwas_pkg::CFG_READY_TIMEOUT:  r_cfg.ready_timeout_ms  <= i_data;
                cwas_pkg::CFG_SETTLE_TIMEOUT: r_cfg.settle_timeout_ms <= i_data;
                cwas_pkg::CFG_SETTLE_DELAY:   r_cfg.settle_delay_ms   <= i_data;
                cwas_pkg::CFG_IDLE_SLEEP:     r_cfg.idle_sleep_ms     <= i_data;
                cwas_pkg::CFG_EVENT_TIMEOUT:  r_cfg.event_timeout_ms  <= i_data;
                cwas_pkg::CFG_MAX_RETRIES:    r_cfg.max_wake_retries  <= i_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/cwas_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwas_step
// Next-state and result logic for one event item.
// ----------------------------------------------------------------------------
module cwas_step (
    input  cwas_pkg::t_in_item  i_item,
    input  cwas_pkg::t_state    i_state,
    input  cwas_pkg::t_cfg      i_cfg,
    output cwas_pkg::t_state    o_state,
    output cwas_pkg::t_out_item o_result
);

    cwas_pkg::t_state s;
    logic [31:0]      now;
    logic [31:0]      settle_age;
    logic [1:0]       act;
    logic [4:0]       nt;
    logic [1:0]       vr;
    logic [1:0]       rsn;

    always_comb begin
        s   = i_state;
        act = cwas_pkg::ACT_NONE;
        nt  = cwas_pkg::NT_NONE;
        vr  = cwas_pkg::VR_NONE;
        rsn = i_state.capture_reason;

        // Advance the millisecond clock on a tick
        if (i_item.command == cwas_pkg::CMD_TICK) begin
            s.clock_ms = i_state.clock_ms + 32'd1;
        end
        now        = s.clock_ms;
        settle_age = cwas_pkg::since(now, s.settle_due_time);

        case (i_item.command)
            cwas_pkg::CMD_TICK: begin
                // Drop a stale pending capture
                if (s.flags[cwas_pkg::FL_CAPPEND] &&
                    cwas_pkg::since(now, s.capture_start_time) >
                    cwas_pkg::ms32(i_cfg.event_timeout_ms)) begin
                    s.flags[cwas_pkg::FL_CAPPEND] = 1'b0;
                end
                // Timed part of the arm sequence
                case (s.arm_state)
                    cwas_pkg::ST_WAKING: begin
                        if (s.wake_retry_count == 4'd0 ||
                            cwas_pkg::since(now, s.wake_pulse_time) >=
                            cwas_pkg::ms32(i_cfg.wake_interval_ms)) begin
                            act = cwas_pkg::ACT_WAKE;
                            if (i_item.link_ok) begin
                                s.wake_pulse_time = now;
                                if (s.wake_retry_count != 4'd15) begin
                                    s.wake_retry_count = s.wake_retry_count + 4'd1;
                                end
                                s.last_activity_time = now;
                                nt = cwas_pkg::NT_WAKE_RETRY;
                                s.arm_state = cwas_pkg::ST_WAITBOOT;
                            end
                        end
                    end
                    cwas_pkg::ST_WAITBOOT: begin
                        if (s.flags[cwas_pkg::FL_BOOT]) begin
                            nt = cwas_pkg::NT_BOOT_CONFIRM;
                            s.arm_state = cwas_pkg::ST_WAITREADY;
                        end else if (cwas_pkg::since(now, s.wake_pulse_time) >
                                     cwas_pkg::ms32(i_cfg.boot_timeout_ms)) begin
                            if (s.wake_retry_count < i_cfg.max_wake_retries) begin
                                s.arm_state = cwas_pkg::ST_WAKING;
                            end else begin
                                s.flags[cwas_pkg::FL_METAONLY] = 1'b1;
                                s.capture_reason = cwas_pkg::VR_NO_CAPTURE;
                                nt = cwas_pkg::NT_VISIT_CAPTURE;
                                vr = cwas_pkg::VR_NO_CAPTURE;
                                s.arm_state = cwas_pkg::ST_IDLE;
                            end
                        end
                    end
                    cwas_pkg::ST_WAITREADY: begin
                        if (s.flags[cwas_pkg::FL_READY]) begin
                            nt  = cwas_pkg::NT_READY_DETECT;
                            act = cwas_pkg::ACT_STATUS_REQ;
                            s.arm_state = cwas_pkg::ST_SETTLING;
                        end else if (cwas_pkg::since(now, s.boot_time) >
                                     cwas_pkg::ms32(i_cfg.ready_timeout_ms)) begin
                            s.flags[cwas_pkg::FL_METAONLY] = 1'b1;
                            s.capture_reason = cwas_pkg::VR_LATE;
                            nt = cwas_pkg::NT_VISIT_CAPTURE;
                            vr = cwas_pkg::VR_LATE;
                            s.arm_state = cwas_pkg::ST_IDLE;
                        end
                    end
                    cwas_pkg::ST_SETTLING: begin
                        if (s.flags[cwas_pkg::FL_SETTLED] && !settle_age[31]) begin
                            s.capture_reason = cwas_pkg::VR_ARMED;
                            nt = cwas_pkg::NT_CAPTURE_READY;
                            vr = cwas_pkg::VR_ARMED;
                            s.arm_state = cwas_pkg::ST_READY;
                        end else if (cwas_pkg::since(now, s.ready_time) >
                                     cwas_pkg::ms32(i_cfg.settle_timeout_ms)) begin
                            s.flags[cwas_pkg::FL_METAONLY] = 1'b1;
                            s.capture_reason = cwas_pkg::VR_LATE;
                            nt = cwas_pkg::NT_VISIT_CAPTURE;
                            vr = cwas_pkg::VR_LATE;
                            s.arm_state = cwas_pkg::ST_READY;
                        end
                    end
                    cwas_pkg::ST_READY: begin
                        if (!s.flags[cwas_pkg::FL_VISIT] && !s.flags[cwas_pkg::FL_QUEUED] &&
                            cwas_pkg::since(now, s.ready_time) >
                            cwas_pkg::ms32(i_cfg.idle_sleep_ms)) begin
                            s.arm_state = cwas_pkg::ST_DISARMING;
                        end
                    end
                    cwas_pkg::ST_DISARMING: begin
                        if (!s.flags[cwas_pkg::FL_CAPPEND] &&
                            !s.flags[cwas_pkg::FL_SLEEPING] &&
                            s.flags[cwas_pkg::FL_ACTIVE]) begin
                            act = cwas_pkg::ACT_DEEP_SLEEP;
                            if (i_item.link_ok) begin
                                s.flags[cwas_pkg::FL_SLEEPING] = 1'b1;
                                s.flags[cwas_pkg::FL_SETTLED]  = 1'b0;
                                s.last_activity_time = now;
                                nt = cwas_pkg::NT_DISARM_SLEEP;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                // Idle deep sleep; the timed notice wins if both fire
                if (s.flags[cwas_pkg::FL_ACTIVE] && s.flags[cwas_pkg::FL_SETTLED] &&
                    !s.flags[cwas_pkg::FL_SLEEPING] &&
                    s.arm_state == cwas_pkg::ST_IDLE &&
                    cwas_pkg::since(now, s.last_activity_time) >
                    cwas_pkg::ms32(i_cfg.idle_sleep_ms)) begin
                    act = cwas_pkg::ACT_DEEP_SLEEP;
                    if (i_item.link_ok) begin
                        s.flags[cwas_pkg::FL_SLEEPING] = 1'b1;
                        s.flags[cwas_pkg::FL_SETTLED]  = 1'b0;
                        s.last_activity_time = now;
                        if (nt == cwas_pkg::NT_NONE) begin
                            nt = cwas_pkg::NT_IDLE_SLEEP;
                        end
                    end
                end
            end
            cwas_pkg::CMD_ARM: begin
                // Ignore from waiting for boot through capturing
                if (!(s.arm_state >= cwas_pkg::ST_WAITBOOT &&
                      s.arm_state <= cwas_pkg::ST_CAPTURING)) begin
                    s.flags[cwas_pkg::FL_BOOT]     = 1'b0;
                    s.flags[cwas_pkg::FL_READY]    = 1'b0;
                    s.flags[cwas_pkg::FL_QUEUED]   = 1'b0;
                    s.flags[cwas_pkg::FL_METAONLY] = 1'b0;
                    s.flags[cwas_pkg::FL_MEDIA]    = 1'b0;
                    s.capture_reason  = cwas_pkg::VR_NONE;
                    s.settle_due_time = 32'd0;
                    act = cwas_pkg::ACT_WAKE;
                    if (i_item.link_ok) begin
                        s.wake_pulse_time    = now;
                        s.wake_retry_count   = 4'd1;
                        s.last_activity_time = now;
                        nt = cwas_pkg::NT_WAKE_PULSE;
                        s.arm_state = cwas_pkg::ST_WAITBOOT;
                    end else begin
                        s.wake_pulse_time  = 32'd0;
                        s.wake_retry_count = 4'd0;
                        nt = cwas_pkg::NT_WAKE_FAILED;
                        s.arm_state = cwas_pkg::ST_IDLE;
                    end
                end
            end
            cwas_pkg::CMD_BOOT: begin
                s.flags[cwas_pkg::FL_BOOT] = 1'b1;
                s.boot_time = now;
                nt = cwas_pkg::NT_BOOT_SEEN;
                if (s.arm_state == cwas_pkg::ST_WAKING ||
                    s.arm_state == cwas_pkg::ST_WAITBOOT) begin
                    s.arm_state = cwas_pkg::ST_WAITREADY;
                end
            end
            cwas_pkg::CMD_READY: begin
                s.flags[cwas_pkg::FL_READY] = 1'b1;
                s.ready_time      = now;
                s.settle_due_time = now + cwas_pkg::ms32(i_cfg.settle_delay_ms);
                nt = cwas_pkg::NT_READY_SEEN;
                if (s.arm_state == cwas_pkg::ST_WAITREADY ||
                    s.arm_state == cwas_pkg::ST_SETTLING) begin
                    s.arm_state = cwas_pkg::ST_SETTLING;
                end
            end
            cwas_pkg::CMD_SLEEP_SEEN: begin
                nt = cwas_pkg::NT_SLEEP_SEEN;
                s.arm_state = cwas_pkg::ST_IDLE;
                s.flags[cwas_pkg::FL_BOOT]     = 1'b0;
                s.flags[cwas_pkg::FL_READY]    = 1'b0;
                s.flags[cwas_pkg::FL_QUEUED]   = 1'b0;
                s.flags[cwas_pkg::FL_CAPPEND]  = 1'b0;
                s.flags[cwas_pkg::FL_VISIT]    = 1'b0;
                s.flags[cwas_pkg::FL_MEDIA]    = 1'b0;
                s.flags[cwas_pkg::FL_METAONLY] = 1'b0;
                s.capture_reason = cwas_pkg::VR_NONE;
            end
            cwas_pkg::CMD_STATUS: begin
                s.flags[cwas_pkg::FL_SETTLED] = i_item.module_settled;
                if (i_item.status_kind == cwas_pkg::SK_ACTIVE) begin
                    s.flags[cwas_pkg::FL_ACTIVE]   = 1'b1;
                    s.flags[cwas_pkg::FL_SLEEPING] = 1'b0;
                    if (i_item.module_settled) begin
                        s.last_activity_time = now;
                    end
                end else if (i_item.status_kind == cwas_pkg::SK_SLEEP_DEEP) begin
                    s.flags[cwas_pkg::FL_ACTIVE]   = 1'b0;
                    s.flags[cwas_pkg::FL_SETTLED]  = 1'b0;
                    s.flags[cwas_pkg::FL_SLEEPING] = 1'b0;
                end
            end
            cwas_pkg::CMD_CAP_DONE: begin
                s.flags[cwas_pkg::FL_CAPPEND] = 1'b0;
                s.flags[cwas_pkg::FL_QUEUED]  = 1'b0;
                s.flags[cwas_pkg::FL_MEDIA]   = i_item.capture_ok;
                nt = i_item.capture_ok ? cwas_pkg::NT_CAP_DONE_OK : cwas_pkg::NT_CAP_DONE_FAIL;
                s.arm_state = cwas_pkg::ST_DISARMING;
                s.last_activity_time = now;
            end
            cwas_pkg::CMD_CAP_ISSUED: begin
                if (i_item.link_ok) begin
                    s.last_activity_time = now;
                    s.flags[cwas_pkg::FL_CAPPEND]  = 1'b1;
                    s.flags[cwas_pkg::FL_QUEUED]   = 1'b1;
                    s.flags[cwas_pkg::FL_METAONLY] = 1'b0;
                    s.capture_start_time = now;
                    s.capture_reason = cwas_pkg::VR_ARMED;
                    s.arm_state = cwas_pkg::ST_CAPTURING;
                    nt = cwas_pkg::NT_VISIT_CAPTURE;
                    vr = cwas_pkg::VR_ARMED;
                end
            end
            cwas_pkg::CMD_VISIT_START: begin
                s.flags[cwas_pkg::FL_VISIT] = 1'b1;
                nt = cwas_pkg::NT_VISIT_START;
            end
            cwas_pkg::CMD_VISIT_END: begin
                // Fall back to media or metadata state when no reason is held
                if (rsn == cwas_pkg::VR_NONE) begin
                    if (s.flags[cwas_pkg::FL_MEDIA]) begin
                        rsn = cwas_pkg::VR_ARMED;
                    end else if (s.flags[cwas_pkg::FL_METAONLY]) begin
                        rsn = cwas_pkg::VR_NO_CAPTURE;
                    end else begin
                        rsn = cwas_pkg::VR_LATE;
                    end
                end
                s.flags[cwas_pkg::FL_VISIT]    = 1'b0;
                nt = cwas_pkg::NT_VISIT_END;
                vr = rsn;
                s.capture_reason = cwas_pkg::VR_NONE;
                s.flags[cwas_pkg::FL_METAONLY] = 1'b0;
                s.flags[cwas_pkg::FL_MEDIA]    = 1'b0;
                s.flags[cwas_pkg::FL_QUEUED]   = 1'b0;
                s.arm_state = cwas_pkg::ST_DISARMING;
            end
            default: begin
            end
        endcase
    end

    assign o_state               = s;
    assign o_result.arm_state    = s.arm_state;
    assign o_result.action       = act;
    assign o_result.notice       = nt;
    assign o_result.visit_reason = vr;

endmodule

### design/companion_wake_arm_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// companion_wake_arm_sequencer_core
// Companion camera wake and arm sequencer: one event item in, one result out.
// ----------------------------------------------------------------------------
// Datapath: input register, then one pass of the step logic into the
//   result register.
// Throughput: one item per cycle while the output is ready; sequencer state
//   updates with the result register, so the next item sees it at once.
// Reset: synchronous, active low; state cleared to idle, settings to defaults.
// ----------------------------------------------------------------------------
module companion_wake_arm_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cwas_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cwas_pkg::t_out_item               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cwas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cwas_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                r_in_valid;
    cwas_pkg::t_in_item  r_in;
    logic                r_out_valid;
    cwas_pkg::t_out_item r_out;
    cwas_pkg::t_state    r_st;
    cwas_pkg::t_state    n_st;
    cwas_pkg::t_out_item n_out;
    cwas_pkg::t_cfg      cfg;
    logic                advance;

    // Configuration bank takes every write
    assign o_cfg_ready = 1'b1;

    cwas_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    cwas_step u_step (
        .i_item   (r_in),
        .i_state  (r_st),
        .i_cfg    (cfg),
        .o_state  (n_st),
        .o_result (n_out)
    );

    // Move the held item into the result register when it has room
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Control and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // A visit reason only travels with capture, capture ready or visit end
    a_reason_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.visit_reason != cwas_pkg::VR_NONE) |->
        (r_out.notice == cwas_pkg::NT_VISIT_CAPTURE ||
         r_out.notice == cwas_pkg::NT_CAPTURE_READY ||
         r_out.notice == cwas_pkg::NT_VISIT_END))
        else $error("visit reason with unrelated notice");

    // The millisecond clock steps by at most one per cycle
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        (r_st.clock_ms == $past(r_st.clock_ms) ||
         r_st.clock_ms == $past(r_st.clock_ms) + 32'd1))
        else $error("clock jumped");

    // A stalled result freezes the sequencer state
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_st))
        else $error("state changed under output stall");
`endif

endmodule
